### rtl/nsc_pkg.sv
// Shared types, codes and name tables for the NMEA sentence checker.
package nsc_pkg;

	localparam int NSC_MAX_LINE = 255;

	localparam logic [7:0] CHAR_LF     = 8'h0A;
	localparam logic [7:0] CHAR_STAR   = 8'h2A;
	localparam logic [7:0] CHAR_DOLLAR = 8'h24;

	localparam int NUM_TALKERS = 5;
	localparam int NUM_KINDS   = 12;
	localparam logic [3:0] KIND_UNSUPPORTED = 4'd12;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_SHORT     = 3'd1,
		ST_NO_STAR   = 3'd2,
		ST_CSUM_BAD  = 3'd3,
		ST_NO_DOLLAR = 3'd4,
		ST_BAD_TALK  = 3'd5,
		ST_OVERFLOW  = 3'd6
	} status_t;

	// GP GL GA GB GN
	localparam logic [NUM_TALKERS-1:0][15:0] TALKER_NAMES = {
		16'h474E, 16'h4742, 16'h4741, 16'h474C, 16'h4750
	};

	// GBS GGA GLL GNS GRS GSA GST GSV RMC TXT VLW VTG (entry 0 rightmost)
	localparam logic [NUM_KINDS-1:0][23:0] KIND_NAMES = {
		24'h565447, 24'h564C57, 24'h545854, 24'h524D43,
		24'h475356, 24'h475354, 24'h475341, 24'h475253,
		24'h474E53, 24'h474C4C, 24'h474741, 24'h474253
	};

	typedef struct packed {
		logic [7:0]      count;
		logic [7:0]      xsum;
		logic [5:0][7:0] header;
		logic [4:0][7:0] recent;
		logic            overflowed;
	} line_state_t;

	typedef struct packed {
		status_t    status;
		logic [2:0] talker;
		logic [3:0] kind;
		logic [7:0] len;
	} verdict_t;

	// Non-hex characters count as zero.
	function automatic logic [3:0] hex_value(input logic [7:0] c);
		logic [3:0] v;
		v = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) v = c[3:0];
		else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
			v = c[3:0] + 4'd9;
		return v;
	endfunction

endpackage

### rtl/nsc_line_state.sv
// Per-line accumulator: byte count, running XOR, header and recent-byte shift line.
module nsc_line_state import nsc_pkg::*; #(
	parameter int MAX_LINE = NSC_MAX_LINE
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        take,
	input  logic [7:0]  rx_byte,
	output line_state_t line
);

	line_state_t line_q;
	logic [8:0]  count_inc;

	assign count_inc = {1'b0, line_q.count} + 9'd1;
	assign line = line_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_q <= '0;
		end else if (take) begin
			if (rx_byte == CHAR_LF) begin
				line_q <= '0;
			end else begin
				for (int i = 0; i < 6; i++) begin
					if (line_q.count == 8'(i)) line_q.header[i] <= rx_byte;
				end
				if (line_q.count != 8'd0) line_q.xsum <= line_q.xsum ^ rx_byte;
				if (count_inc > 9'(MAX_LINE)) line_q.overflowed <= 1'b1;
				if (line_q.count != 8'hFF) line_q.count <= count_inc[7:0];
				line_q.recent <= {line_q.recent[3:0], rx_byte};
			end
		end
	end

endmodule

### rtl/nsc_verdict.sv
// Line classification: overflow, length, star, checksum, dollar, talker and type.
module nsc_verdict import nsc_pkg::*; #(
	parameter int MAX_LINE = NSC_MAX_LINE
) (
	input  line_state_t line,
	output verdict_t    verdict
);

	always_comb begin
		logic [8:0] len_full;
		logic [7:0] x;
		logic [7:0] sum;
		logic       tk_hit;
		logic [2:0] tk;
		logic [3:0] kd;

		len_full = {1'b0, line.count} + 9'd1;
		x = line.xsum ^ line.recent[0] ^ line.recent[1] ^ line.recent[2] ^ line.recent[3];
		sum = {hex_value(line.recent[2]), hex_value(line.recent[1])};

		tk_hit = 1'b0;
		tk = 3'd0;
		for (int i = NUM_TALKERS - 1; i >= 0; i--) begin
			if ({line.header[1], line.header[2]} == TALKER_NAMES[i]) begin
				tk_hit = 1'b1;
				tk = 3'(i);
			end
		end

		kd = KIND_UNSUPPORTED;
		for (int i = NUM_KINDS - 1; i >= 0; i--) begin
			if ({line.header[3], line.header[4], line.header[5]} == KIND_NAMES[i])
				kd = 4'(i);
		end

		verdict.len    = len_full[8] ? 8'hFF : len_full[7:0];
		verdict.talker = 3'd0;
		verdict.kind   = 4'd0;
		if (line.overflowed || len_full > 9'(MAX_LINE))
			verdict.status = ST_OVERFLOW;
		else if (len_full < 9'd6)
			verdict.status = ST_SHORT;
		else if (line.recent[3] != CHAR_STAR)
			verdict.status = ST_NO_STAR;
		else if (sum != x)
			verdict.status = ST_CSUM_BAD;
		else if (line.header[0] != CHAR_DOLLAR)
			verdict.status = ST_NO_DOLLAR;
		else if (!tk_hit)
			verdict.status = ST_BAD_TALK;
		else begin
			verdict.status = ST_OK;
			verdict.talker = tk;
			verdict.kind   = kd;
		end
	end

endmodule

### rtl/nmea_sentence_checker_unit.sv
// Top level: NMEA 0183 line splitter and checksum checker with a registered verdict.
// The verdict for a line is registered and valid in the cycle after its LF transaction.
// Throughput: one byte per cycle while the verdict sink keeps up; the line state updates on every accepted byte.
// Any byte, LF or not, waits while an unread verdict is held and out_ready is low.
// Reset (arst_n low, asynchronous) clears the line state and drops out_valid.
module nmea_sentence_checker_unit import nsc_pkg::*; #(
	parameter int MAX_LINE = NSC_MAX_LINE
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [2:0] status,
	output logic [2:0] talker,
	output logic [3:0] sentence_kind,
	output logic [7:0] line_length
);

	line_state_t line;
	verdict_t    verdict;
	verdict_t    verdict_q;
	logic        out_valid_q;
	logic        take;
	logic        is_lf;

	// Only an LF needs the result slot, but holding every byte while a
	// verdict is stalled keeps the ready term simple and still allows a
	// byte every cycle while the sink keeps up.
	assign in_ready = !out_valid_q || out_ready;
	assign take     = in_valid && in_ready;
	assign is_lf    = rx_byte == CHAR_LF;

	// Accumulates the current line; cleared by the LF that ends it.
	nsc_line_state #(.MAX_LINE(MAX_LINE)) u_line (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (take),
		.rx_byte (rx_byte),
		.line    (line)
	);

	// Verdict is formed from the state before the LF is folded in.
	nsc_verdict #(.MAX_LINE(MAX_LINE)) u_verdict (
		.line    (line),
		.verdict (verdict)
	);

	// Result register: loaded on an LF transaction, released on output transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take && is_lf) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && is_lf) verdict_q <= verdict;
	end

	assign out_valid     = out_valid_q;
	assign status        = verdict_q.status;
	assign talker        = verdict_q.talker;
	assign sentence_kind = verdict_q.kind;
	assign line_length   = verdict_q.len;

	// An LF transaction always yields a verdict and restarts the line.
	a_lf_result: assert property (@(posedge clk) disable iff (!arst_n)
		take && is_lf |=> out_valid && line.count == 8'd0)
		else $error("LF transaction did not produce a verdict or clear the line");

	// A passing line is at least a minimal sentence.
	a_ok_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_OK |-> line_length >= 8'd6)
		else $error("OK verdict on a line shorter than six bytes");

	// Codes are zero unless the line passed.
	a_codes_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> talker == 3'd0 && sentence_kind == 4'd0)
		else $error("talker or kind set on a rejected line");

	// A non-LF transaction never creates a verdict by itself.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid && !(take && is_lf) |=> !out_valid)
		else $error("verdict appeared without an LF");

endmodule
